[src/address_region_table_top_macros.svh]
// Assertion macros for the address region table.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ADDRESS_REGION_TABLE_TOP_MACROS_SVH
`define ADDRESS_REGION_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ART_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address region table: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address region table: next-cycle check failed");

`else

`define ART_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/art_pkg.sv]
// Shared types, codes and helper functions for the address region table.
// No dependencies; used by the top level.
package art_pkg;

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_FIND  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_MISS   = 2'd2;

   // Owner class codes.
   localparam logic [2:0] CLASS_RESIDENT = 3'd0;
   localparam logic [2:0] CLASS_TASK     = 3'd1;
   localparam logic [2:0] CLASS_LIBRARY  = 3'd2;
   localparam logic [2:0] CLASS_DEVICE   = 3'd3;
   localparam logic [2:0] CLASS_OTHER    = 3'd4;

   // Widths fixed by the channel fields.
   localparam int FIELD_ADDR_W = 32;
   localparam int COUNT_OUT_W  = 6;

   // One request word.
   typedef struct packed {
      logic [1:0]              cmd;
      logic [2:0]              inventory_kind;
      logic [15:0]             name_tag;
      logic [FIELD_ADDR_W-1:0] range_start;
      logic [FIELD_ADDR_W-1:0] range_end;
      logic                    exec_flag;
      logic                    patch_flag;
      logic [FIELD_ADDR_W-1:0] lookup_address;
      logic [4:0]              entry_index;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [1:0]              status;
      logic [FIELD_ADDR_W-1:0] found_start;
      logic [FIELD_ADDR_W-1:0] found_end;
      logic [2:0]              owner_class;
      logic [15:0]             owner_tag;
      logic                    is_executable;
      logic                    may_patch;
      logic [COUNT_OUT_W-1:0]  entry_count;
   } rsp_type;

   // Attributes stored with each entry.
   typedef struct packed {
      logic [2:0]  owner_class;
      logic [15:0] tag;
      logic        exec_flag;
      logic        patch_flag;
   } attr_type;

   localparam int ATTR_W = $bits(attr_type);

   // Known inventory kinds pass through; every other kind becomes the other class.
   function automatic logic [2:0] map_kind(input logic [2:0] kind);
      logic [2:0] owner;
      owner = (kind <= CLASS_DEVICE) ? kind : CLASS_OTHER;
      return owner;
   endfunction

endpackage

[src/art_chan_if.sv]
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; the payload type is supplied by the instantiating code.
interface art_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/art_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module art_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    write_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                        write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                        read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

[src/address_region_table_top.sv]
// Address region table: top level with the command sequencer and the scan comparator.
// Depends on art_pkg, art_chan_if, art_ram and address_region_table_top_macros.svh.
//
// The block holds up to TABLE_DEPTH address regions in one RAM and serves one request
// word at a time, returning exactly one response word per request. Add, clear and
// read-beyond-count pass from the execute state straight to the done state; a valid
// read passes through the read state in between, where the RAM word is registered.
// Find reads the entries in table order through the single RAM read port, one entry
// per cycle, stopping at the first match or after the last filled entry. The next
// request is taken in the cycle after the response is loaded into the output register,
// even if the consumer has not yet taken it. Stored entries need no clearing after
// reset; only the entry count is reset.
`include "address_region_table_top_macros.svh"

module address_region_table_top
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int ADDR_WIDTH  = 32
) (
   input logic         clock,
   input logic         reset,
   art_chan_if.sink    req_chan,
   art_chan_if.source  rsp_chan
);

   // Address bits actually kept, table index and count widths.
   localparam int AW      = (ADDR_WIDTH < FIELD_ADDR_W) ? ADDR_WIDTH : FIELD_ADDR_W;
   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W   = CNT_W + 5;
   localparam int ENTRY_W = ATTR_W + 2 * AW;

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0] cmp_next;
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic [AW-1:0] add_start;
   logic [AW-1:0] add_end;
   logic [AW-1:0] look_addr;
   logic [AW-1:0] ent_start;
   logic [AW-1:0] ent_end;
   attr_type      add_attr;
   attr_type      ent_attr;
   logic          add_bad;
   logic          idx_ok;
   logic          hit;
   rsp_type       ent_rsp;

   // Entry storage: one word per region holding attributes, end and start.
   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   // Fields of the latched request, reduced to the kept address width.
   assign add_start = req_ff.range_start[AW-1:0];
   assign add_end   = req_ff.range_end[AW-1:0];
   assign look_addr = req_ff.lookup_address[AW-1:0];

   always_comb begin
      add_attr.owner_class = map_kind(req_ff.inventory_kind);
      add_attr.tag         = req_ff.name_tag;
      add_attr.exec_flag   = req_ff.exec_flag;
      add_attr.patch_flag  = req_ff.patch_flag;
   end

   assign add_bad = (add_start > add_end) || (count_ff == CNT_W'(TABLE_DEPTH));
   assign idx_ok  = CMP_W'(req_ff.entry_index) < CMP_W'(count_ff);

   // Unpack the word returned by the RAM.
   assign ent_start = ram_rdata[AW-1:0];
   assign ent_end   = ram_rdata[2*AW-1:AW];
   assign ent_attr  = attr_type'(ram_rdata[ENTRY_W-1:2*AW]);

   // Shared range comparator, used once per scanned entry.
   assign hit = (look_addr >= ent_start) && (look_addr <= ent_end);

   always_comb begin
      ent_rsp               = '0;
      ent_rsp.status        = STATUS_OK;
      ent_rsp.found_start   = FIELD_ADDR_W'(ent_start);
      ent_rsp.found_end     = FIELD_ADDR_W'(ent_end);
      ent_rsp.owner_class   = ent_attr.owner_class;
      ent_rsp.owner_tag     = ent_attr.tag;
      ent_rsp.is_executable = ent_attr.exec_flag;
      ent_rsp.may_patch     = ent_attr.patch_flag;
   end

   assign cmp_next = cmp_idx_ff + CNT_W'(1);

   // Sequencer: next state, table update, RAM addressing and result assembly.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmp_idx_in   = cmp_idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = IDX_W'(count_ff);
      ram_wdata    = {add_attr, add_end, add_start};
      ram_raddr    = '0;

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in        = '0;
            res_in.status = STATUS_OK;
            unique case (req_ff.cmd)
               CMD_ADD: begin
                  if (add_bad) begin
                     res_in.status = STATUS_REJECT;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_DONE;
               end
               CMD_FIND: begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_MISS;
                     state_in      = S_DONE;
                  end else begin
                     ram_raddr  = '0;
                     cmp_idx_in = '0;
                     state_in   = S_SCAN;
                  end
               end
               CMD_READ: begin
                  if (idx_ok) begin
                     ram_raddr = IDX_W'(req_ff.entry_index);
                     state_in  = S_READ;
                  end else begin
                     res_in.status = STATUS_MISS;
                     state_in      = S_DONE;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            res_in   = ent_rsp;
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (hit) begin
               res_in   = ent_rsp;
               state_in = S_DONE;
            end else if (cmp_next == count_ff) begin
               res_in        = '0;
               res_in.status = STATUS_MISS;
               state_in      = S_DONE;
            end else begin
               ram_raddr  = IDX_W'(cmp_next);
               cmp_idx_in = cmp_next;
            end
         end
         S_DONE: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.entry_count = COUNT_OUT_W'(count_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      cmp_idx_ff  <= cmp_idx_in;
   end

   // Channel outputs.
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // The table never holds more entries than it has room for.
   `ART_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))

   // An accepted word always goes to the execute step next.
   `ART_ASSERT_NEXT(a_accept_exec, clock, reset, req_chan.valid && req_chan.ready,
                    state_ff == S_EXEC)

   // The scan position stays inside the filled part of the table.
   `ART_ASSERT_IMPL(a_scan_range, clock, reset, state_ff == S_SCAN, cmp_idx_ff < count_ff)

   // A finished result with a free output slot is offered in the next cycle.
   `ART_ASSERT_NEXT(a_done_offer, clock, reset,
                    state_ff == S_DONE && (!rsp_chan.valid || rsp_chan.ready),
                    rsp_chan.valid && state_ff == S_IDLE)

endmodule
